// File: rtl/core/odt_pkg.sv
// ----------------------------------------------------------------------------
// odt_pkg
// Types, constants and helpers for the object dictionary table.
// ----------------------------------------------------------------------------
package odt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [1:0] FUNC_REGISTER = 2'd0;
   localparam logic [1:0] FUNC_READ     = 2'd1;
   localparam logic [1:0] FUNC_WRITE    = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] object_index;
      logic [7:0]  object_subindex;
      logic [7:0]  length;
      logic [31:0] value;
      logic        protect;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [2:0]  read_len;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key_index;
      logic [7:0]  key_subindex;
      logic [2:0]  size;
      logic        locked;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         entry;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tbl_rd_type;

   // low n bytes set, n from 1 to 4
   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      logic [31:0] m;
      begin
         unique case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
         endcase
         return m;
      end
   endfunction

endpackage

// File: rtl/core/odt_table.sv
// ----------------------------------------------------------------------------
// odt_table
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module odt_table
   import odt_pkg::*;
(
   input  logic       clock,
   input  tbl_wr_type wr,
   input  tbl_rd_type rd,
   output entry_type  rd_entry
);

   entry_type mem [MAX_ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_entry_ff <= mem[rd.addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: rtl/core/odt_ctrl.sv
// ----------------------------------------------------------------------------
// odt_ctrl
// Sequencer: appends entries and scans the table one entry a cycle through
// a single key comparator.
// ----------------------------------------------------------------------------
module odt_ctrl
   import odt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  req_type    req_data,
   output logic       busy,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   output tbl_wr_type wr,
   output tbl_rd_type rd,
   input  entry_type  rd_entry
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN
   } state_type;

   state_type       state_ff;
   req_type         req_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic [ADDR_W-1:0] cmp_ptr_ff;
   logic            cmp_vld_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic            hit;
   logic            reg_ok;
   logic            table_full;
   logic [2:0]      wr_bytes;
   logic [31:0]     wr_mask;

   assign table_full = (count_ff == CNT_W'(MAX_ENTRIES));
   assign reg_ok     = (req_ff.length >= 8'd1) && (req_ff.length <= 8'd4) && !table_full;
   assign hit        = cmp_vld_ff
                       && (rd_entry.key_index == req_ff.object_index)
                       && (rd_entry.key_subindex == req_ff.object_subindex);
   assign wr_bytes   = (req_ff.length < {5'd0, rd_entry.size}) ? req_ff.length[2:0]
                                                               : rd_entry.size;
   assign wr_mask    = byte_mask(wr_bytes);

   always_comb begin
      wr       = '0;
      rd       = '0;
      rd.addr  = ptr_ff[ADDR_W-1:0];
      if (state_ff == ST_DECODE && req_ff.func == FUNC_REGISTER && reg_ok) begin
         wr.en                 = 1'b1;
         wr.addr               = count_ff[ADDR_W-1:0];
         wr.entry.key_index    = req_ff.object_index;
         wr.entry.key_subindex = req_ff.object_subindex;
         wr.entry.size         = req_ff.length[2:0];
         wr.entry.locked       = req_ff.protect;
         wr.entry.value        = req_ff.value & byte_mask(req_ff.length[2:0]);
      end else if (state_ff == ST_SCAN && hit && req_ff.func == FUNC_WRITE
                   && !rd_entry.locked) begin
         wr.en          = 1'b1;
         wr.addr        = cmp_ptr_ff;
         wr.entry       = rd_entry;
         wr.entry.value = (rd_entry.value & ~wr_mask) | (req_ff.value & wr_mask);
      end
      if (state_ff == ST_SCAN && !hit && ptr_ff < count_ff) begin
         rd.en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               rsp_ff     <= '0;
               ptr_ff     <= '0;
               cmp_vld_ff <= 1'b0;
               priority if (req_ff.func == FUNC_REGISTER) begin
                  rsp_ff.ok    <= reg_ok;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (reg_ok) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end else if (req_ff.func == FUNC_READ
                            || (req_ff.func == FUNC_WRITE && req_ff.length != 8'd0)) begin
                  state_ff <= ST_SCAN;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               cmp_vld_ff <= rd.en;
               if (rd.en) begin
                  ptr_ff     <= ptr_ff + CNT_W'(1);
                  cmp_ptr_ff <= ptr_ff[ADDR_W-1:0];
               end
               if (hit) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (req_ff.func == FUNC_READ) begin
                     rsp_ff.ok         <= 1'b1;
                     rsp_ff.read_value <= rd_entry.value;
                     rsp_ff.read_len   <= rd_entry.size;
                  end else begin
                     rsp_ff.ok <= !rd_entry.locked;
                  end
               end else if (!rd.en && !cmp_vld_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/object_dictionary_table_top.sv
// ----------------------------------------------------------------------------
// object_dictionary_table_top
// Keyed object table: register, read and write of dictionary entries.
// Register and failed decode results are registered from the decode state;
// read/write results come from the table scan, one table entry compared a cycle.
// One beat at a time: busy falls as the result strobe rises, so the next beat can
// be accepted at the edge ending the strobe; the receiver cannot stall.
// Reset clears the entry count; table contents are not cleared.
// ----------------------------------------------------------------------------
module object_dictionary_table_top
   import odt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   tbl_wr_type wr;
   tbl_rd_type rd;
   entry_type  rd_entry;

   odt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .wr        (wr),
      .rd        (rd),
      .rd_entry  (rd_entry)
   );

   odt_table u_table (
      .clock    (clock),
      .wr       (wr),
      .rd       (rd),
      .rd_entry (rd_entry)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on consecutive cycles");

   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (busy && !rd.en))
      else $error("table write outside an operation or during scan read");

endmodule
